>>> rtl/tsi_pkg.sv
// Shared types and constants for the thrust-to-signal interpolator.
// Item kinds, status codes and fixed-point widths; no dependencies.
package tsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SIG_W     = FRAC_BITS + 1;
	localparam int THR_W     = 16;
	localparam int DES_W     = FRAC_BITS + 2;
	localparam int KIND_W    = 2;
	localparam int ST_W      = 4;
	localparam int DVD_W     = 2 * SIG_W;

	localparam logic [SIG_W-1:0] ONE_FX = SIG_W'(1) << FRAC_BITS;

	typedef enum logic [KIND_W-1:0] {
		K_BEGIN  = 2'd0,
		K_ADD    = 2'd1,
		K_FINISH = 2'd2,
		K_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK           = 4'd0,
		ST_FULL         = 4'd1,
		ST_BAD_FIRST    = 4'd2,
		ST_NOT_INCR     = 4'd3,
		ST_FEW          = 4'd4,
		ST_LAST_NOT_ONE = 4'd5,
		ST_RANGE        = 4'd6,
		ST_NOT_READY    = 4'd7,
		ST_NONE         = 4'd8
	} status_t;

endpackage

>>> rtl/tsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsi_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/tsi_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tsi_pkg for operand widths.
module tsi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tsi_pkg::DVD_W-1:0]  dividend,
	input  logic [tsi_pkg::SIG_W-1:0]  divisor,
	output logic                       done,
	output logic [tsi_pkg::SIG_W-1:0]  quotient
);
	import tsi_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [SIG_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [SIG_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [SIG_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= !start && busy_q && cnt_q == CNT_W'(1);
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= CNT_W'(DVD_W);
				rem_q    <= '0;
				dvd_q    <= dividend;
				dsr_q    <= divisor;
				quotient <= '0;
			end else if (busy_q) begin
				rem_q    <= fits ? SIG_W'(trial - {1'b0, dsr_q}) : trial[SIG_W-1:0];
				dvd_q    <= dvd_q << 1;
				quotient <= {quotient[SIG_W-2:0], fits};
				cnt_q    <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q && cnt_q == '0) else $error("done without finished count");
endmodule

>>> rtl/thrust_to_signal_interpolator.sv
// Thrust-to-signal interpolator: top level with sequencer, point stores and output register.
// Depends on tsi_pkg, tsi_ram and tsi_div.
//
// One item is taken at a time and gives one result item; the input stays
// stalled until the result sits in the output register. Begin, rejected and
// trivial items go straight to the output register; add reads the previous point
// and checks against it. A query scans the table one entry at a time, then reads
// the lower point, multiplies and runs the serial divide (34 quotient steps and a hand-over).
// Finish checks the last point, then normalizes every point, one at a time,
// through the same serial divider. The single divider and the one read port
// of each point store keep this work serial; a held result stalls the input
// further. No clearing pass.
module thrust_to_signal_interpolator #(
	parameter int MAX_POINTS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tsi_pkg::KIND_W-1:0]  kind,
	input  logic [tsi_pkg::SIG_W-1:0]   point_signal,
	input  logic [tsi_pkg::THR_W-1:0]   point_thrust,
	input  logic signed [tsi_pkg::DES_W-1:0] desired_thrust,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tsi_pkg::ST_W-1:0]    status,
	output logic [tsi_pkg::SIG_W-1:0]   motor_signal
);
	import tsi_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_W, S_ADD_C, S_FIN_W, S_FIN_C, S_NRM_W, S_NRM_ST, S_NRM_DV,
		S_QRY_W, S_QRY_C, S_QLO_W, S_QLO_C, S_QMUL, S_QDS, S_QDV, S_DONE
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic             ready_q;
	status_t          err_q;
	logic [SIG_W-1:0] sig_q;
	logic [THR_W-1:0] thr_q;
	logic [SIG_W-1:0] d_q;
	logic [SIG_W-1:0] top_q;
	logic [SIG_W-1:0] t1_q, s1_q, s0_q;
	logic [SIG_W-1:0] a_q, b_q, den_q;
	logic [DVD_W-1:0] prod_q;
	status_t          res_st_q;
	logic [SIG_W-1:0] res_sig_q;

	logic             s_we, t_we;
	logic [AW-1:0]    waddr;
	logic [SIG_W-1:0] t_wdata;
	logic [SIG_W-1:0] s_rd, t_rd;
	status_t          add_st;
	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dvd;
	logic [SIG_W-1:0] div_dsr, div_quo;
	logic [CW-1:0]    idx_nx;

	assign in_stall = state_q != S_IDLE;
	assign idx_nx   = idx_q + CW'(1);

	always_comb begin
		if (cnt_q == '0) begin
			add_st = (sig_q != '0 || thr_q != '0) ? ST_BAD_FIRST : ST_OK;
		end else begin
			add_st = (sig_q <= s_rd || {1'b0, thr_q} <= t_rd) ? ST_NOT_INCR : ST_OK;
		end
	end

	assign s_we    = state_q == S_ADD_C && add_st == ST_OK;
	assign t_we    = s_we || (state_q == S_NRM_DV && div_done);
	assign waddr   = (state_q == S_NRM_DV) ? idx_q[AW-1:0] : cnt_q[AW-1:0];
	assign t_wdata = (state_q == S_NRM_DV) ? div_quo : {1'b0, thr_q};

	assign div_start = state_q == S_NRM_ST || state_q == S_QDS;
	assign div_dvd   = (state_q == S_NRM_ST) ? {1'b0, t_rd, {FRAC_BITS{1'b0}}} : prod_q;
	assign div_dsr   = (state_q == S_NRM_ST) ? top_q : den_q;

	tsi_ram #(.WIDTH(SIG_W), .DEPTH(MAX_POINTS)) u_sig_ram (
		.clk(clk), .we(s_we), .waddr(waddr), .wdata(sig_q),
		.raddr(idx_q[AW-1:0]), .rdata(s_rd)
	);

	tsi_ram #(.WIDTH(SIG_W), .DEPTH(MAX_POINTS)) u_thr_ram (
		.clk(clk), .we(t_we), .waddr(waddr), .wdata(t_wdata),
		.raddr(idx_q[AW-1:0]), .rdata(t_rd)
	);

	tsi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dsr), .done(div_done), .quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			ready_q   <= 1'b0;
			err_q     <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sig_q <= point_signal;
						thr_q <= point_thrust;
						d_q   <= desired_thrust[SIG_W-1:0];
						case (kind_t'(kind))
							K_BEGIN: begin
								cnt_q     <= '0;
								ready_q   <= 1'b0;
								err_q     <= ST_OK;
								res_sig_q <= '0;
								res_st_q  <= ST_OK;
								state_q   <= S_DONE;
							end
							K_ADD, K_FINISH: begin
								res_sig_q <= '0;
								if (err_q != ST_OK) begin
									res_st_q <= err_q;
									state_q  <= S_DONE;
								end else if (ready_q) begin
									res_st_q <= ST_NOT_READY;
									state_q  <= S_DONE;
								end else if (kind_t'(kind) == K_ADD) begin
									if (cnt_q >= CW'(MAX_POINTS)) begin
										res_st_q <= ST_FULL;
										err_q    <= ST_FULL;
										state_q  <= S_DONE;
									end else begin
										res_st_q <= ST_OK;
										idx_q    <= cnt_q - CW'(1);
										state_q  <= S_ADD_W;
									end
								end else if (cnt_q < CW'(2)) begin
									res_st_q <= ST_FEW;
									err_q    <= ST_FEW;
									state_q  <= S_DONE;
								end else begin
									res_st_q <= ST_OK;
									idx_q    <= cnt_q - CW'(1);
									state_q  <= S_FIN_W;
								end
							end
							default: begin
								if (!ready_q) begin
									res_st_q  <= ST_NOT_READY;
									res_sig_q <= '0;
									state_q   <= S_DONE;
								end else if (desired_thrust[DES_W-1]
										|| desired_thrust[SIG_W-1:0] > ONE_FX) begin
									res_st_q  <= ST_RANGE;
									res_sig_q <= '0;
									state_q   <= S_DONE;
								end else if (desired_thrust[SIG_W-1:0] == '0
										|| desired_thrust[SIG_W-1:0] == ONE_FX) begin
									res_st_q  <= ST_OK;
									res_sig_q <= desired_thrust[SIG_W-1:0];
									state_q   <= S_DONE;
								end else begin
									res_st_q  <= ST_OK;
									res_sig_q <= '0;
									idx_q     <= CW'(1);
									state_q   <= S_QRY_W;
								end
							end
						endcase
					end
				end
				S_ADD_W: state_q <= S_ADD_C;
				S_ADD_C: begin
					res_st_q <= add_st;
					err_q    <= add_st;
					if (add_st == ST_OK) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_FIN_W: state_q <= S_FIN_C;
				S_FIN_C: begin
					if (s_rd != ONE_FX) begin
						res_st_q <= ST_LAST_NOT_ONE;
						err_q    <= ST_LAST_NOT_ONE;
						state_q  <= S_DONE;
					end else if (t_rd == '0) begin
						res_st_q <= ST_NOT_INCR;
						err_q    <= ST_NOT_INCR;
						state_q  <= S_DONE;
					end else begin
						top_q   <= t_rd;
						idx_q   <= '0;
						state_q <= S_NRM_W;
					end
				end
				S_NRM_W:  state_q <= S_NRM_ST;
				S_NRM_ST: state_q <= S_NRM_DV;
				S_NRM_DV: begin
					if (div_done) begin
						if (idx_nx == cnt_q) begin
							ready_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_nx;
							state_q <= S_NRM_W;
						end
					end
				end
				S_QRY_W: state_q <= S_QRY_C;
				S_QRY_C: begin
					if (d_q <= t_rd) begin
						t1_q    <= t_rd;
						s1_q    <= s_rd;
						idx_q   <= idx_q - CW'(1);
						state_q <= S_QLO_W;
					end else if (idx_nx >= cnt_q) begin
						res_st_q <= ST_NONE;
						state_q  <= S_DONE;
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_QRY_W;
					end
				end
				S_QLO_W: state_q <= S_QLO_C;
				S_QLO_C: begin
					if (t1_q <= t_rd || d_q < t_rd || s1_q < s_rd) begin
						res_sig_q <= s1_q;
						state_q   <= S_DONE;
					end else begin
						a_q     <= d_q - t_rd;
						b_q     <= s1_q - s_rd;
						den_q   <= t1_q - t_rd;
						s0_q    <= s_rd;
						state_q <= S_QMUL;
					end
				end
				S_QMUL: begin
					prod_q  <= a_q * b_q;
					state_q <= S_QDS;
				end
				S_QDS: state_q <= S_QDV;
				S_QDV: begin
					if (div_done) begin
						res_sig_q <= s0_q + div_quo;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid    <= 1'b1;
						status       <= res_st_q;
						motor_signal <= (res_st_q == ST_OK) ? res_sig_q : '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> motor_signal == '0)
		else $error("error result carries a signal");
	a_ready_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> cnt_q >= CW'(2)) else $error("ready table with too few points");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("point count past capacity");
	a_ready_err: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> err_q == ST_OK) else $error("ready table with load error");
endmodule

>>> dv/thrust_to_signal_interpolator_tb.sv
// Testbench for thrust_to_signal_interpolator: table loads, finishes and queries,
// checked against an in-bench predictor of the interpolation. Depends on tsi_pkg.
module thrust_to_signal_interpolator_tb;
	import tsi_pkg::*;

	localparam int NPTS = 32;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		kind_t                   kind;
		logic [SIG_W-1:0]        sig;
		logic [THR_W-1:0]        thr;
		logic signed [DES_W-1:0] des;
	} cmd_t;

	typedef struct packed {
		status_t          st;
		logic [SIG_W-1:0] sig;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [SIG_W-1:0] point_signal = '0;
	logic [THR_W-1:0] point_thrust = '0;
	logic signed [DES_W-1:0] desired_thrust = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ST_W-1:0] status;
	logic [SIG_W-1:0] motor_signal;

	cmd_t pending[$];
	answer_t answers_due[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_rx = 0;

	logic [SIG_W-1:0] tbl_sig[NPTS];
	logic [31:0] tbl_thr[NPTS];
	int n_pts = 0;
	bit ready = 0;
	status_t load_err = ST_OK;

	thrust_to_signal_interpolator u_dut (.*);

	always #2 clk = ~clk;

	function automatic answer_t interpolate(cmd_t c);
		answer_t a;
		logic [63:0] top, d, t0, t1, s0, s1;
		a.st = ST_OK;
		a.sig = '0;
		case (c.kind)
			K_BEGIN: begin
				n_pts = 0;
				ready = 0;
				load_err = ST_OK;
			end
			K_ADD, K_FINISH: begin
				if (load_err != ST_OK) a.st = load_err;
				else if (ready) a.st = ST_NOT_READY;
				else begin
					if (c.kind == K_ADD) begin
						if (n_pts >= NPTS) a.st = ST_FULL;
						else if (n_pts == 0 && (c.sig != 0 || c.thr != 0)) a.st = ST_BAD_FIRST;
						else if (n_pts > 0 && (c.sig <= tbl_sig[n_pts-1] ||
								c.thr <= tbl_thr[n_pts-1])) a.st = ST_NOT_INCR;
						else begin
							tbl_sig[n_pts] = c.sig;
							tbl_thr[n_pts] = c.thr;
							n_pts++;
						end
					end else begin
						if (n_pts < 2) a.st = ST_FEW;
						else if (tbl_sig[n_pts-1] != ONE_FX) a.st = ST_LAST_NOT_ONE;
						else if (tbl_thr[n_pts-1] == 0) a.st = ST_NOT_INCR;
						else begin
							top = tbl_thr[n_pts-1];
							for (int i = 0; i < n_pts; i++)
								tbl_thr[i] = 32'((64'(tbl_thr[i]) << FRAC_BITS) / top);
							ready = 1;
						end
					end
					load_err = a.st;
				end
			end
			default: begin
				if (!ready) a.st = ST_NOT_READY;
				else if (c.des < 0 || c.des > $signed({1'b0, ONE_FX})) a.st = ST_RANGE;
				else begin
					d = 64'(c.des);
					if (d == 0 || d == ONE_FX) a.sig = SIG_W'(d);
					else begin
						a.st = ST_NONE;
						for (int i = 1; i < n_pts; i++) begin
							t1 = tbl_thr[i];
							if (a.st == ST_NONE && d <= t1) begin
								t0 = tbl_thr[i-1];
								s0 = tbl_sig[i-1];
								s1 = tbl_sig[i];
								a.st = ST_OK;
								if (t1 <= t0 || d < t0 || s1 < s0) a.sig = SIG_W'(s1);
								else a.sig = SIG_W'(s0 + ((d - t0) * (s1 - s0)) / (t1 - t0));
							end
						end
					end
				end
			end
		endcase
		return a;
	endfunction

	function automatic cmd_t mk(kind_t k, int s, int t, int d);
		cmd_t c;
		c.kind = k;
		c.sig = SIG_W'(s);
		c.thr = THR_W'(t);
		c.des = DES_W'(d);
		return c;
	endfunction

	task automatic load_table(int n, bit clean);
		int s, t;
		s = 0;
		t = 0;
		pending.push_back(mk(K_BEGIN, $urandom, $urandom, $urandom));
		pending.push_back(mk(K_ADD, 0, 0, $urandom));
		for (int i = 1; i < n; i++) begin
			if (i == n - 1) s = 65536;
			else s = s + $urandom_range(1, (65535 - s) / (n - i));
			t = t + $urandom_range(1, (65535 - t) / (n - i));
			if (!clean && $urandom_range(0, 9) == 0) begin
				s = $urandom_range(0, 65536);
				t = $urandom_range(0, 65535);
			end
			pending.push_back(mk(K_ADD, s, t, $urandom));
		end
		if (!clean && $urandom_range(0, 4) == 0)
			pending.push_back(mk(K_ADD, $urandom_range(0, 131071), $urandom, $urandom));
		pending.push_back(mk(K_FINISH, $urandom, $urandom, $urandom));
	endtask

	task automatic queries(int n);
		int d;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: d = $urandom_range(0, 262143);
				1: d = $urandom_range(65530, 65542);
				default: d = $urandom_range(1, 65535);
			endcase
			pending.push_back(mk(K_QUERY, $urandom, $urandom, d));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				answers_due.push_back(interpolate({kind_t'(kind), point_signal,
					point_thrust, desired_thrust}));
				void'(pending.pop_front());
			end
			if (in_valid && in_stall) begin
			end else if (pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
				in_valid <= 1'b1;
				{kind, point_signal, point_thrust, desired_thrust} <=
					(in_valid && !in_stall) ? pending[0] : pending[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			cycles++;
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected item status=%0d signal=%0d", $time, status,
						motor_signal);
					errors++;
				end else begin
					e = answers_due.pop_front();
					if (status != e.st || motor_signal != e.sig) begin
						$display("%0t: mismatch expected status=%0d signal=%0d %s",
							$time, e.st, e.sig, "actual");
						$display("%0t: actual status=%0d signal=%0d",
							$time, status, motor_signal);
						errors++;
					end
				end
			end
			out_stall <= hold_rx || (!quiet && $urandom_range(0, 99) < 23);
			if (cycles > LIMIT) begin
				$display("[thrust_to_signal_interpolator] ERROR");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending.size() > 0 || answers_due.size() > 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed: not ready, bad first, few, last not one, not increasing, ready, queries
		pending.push_back(mk(K_QUERY, 0, 0, 100));
		pending.push_back(mk(K_ADD, 0, 0, 0));
		pending.push_back(mk(K_FINISH, 0, 0, 0));
		pending.push_back(mk(K_BEGIN, 0, 0, 0));
		pending.push_back(mk(K_ADD, 5, 0, 0));
		pending.push_back(mk(K_ADD, 0, 0, 0));
		pending.push_back(mk(K_BEGIN, 0, 0, 0));
		pending.push_back(mk(K_ADD, 0, 0, 0));
		pending.push_back(mk(K_ADD, 131071, 65535, 0));
		pending.push_back(mk(K_FINISH, 0, 0, 0));
		pending.push_back(mk(K_BEGIN, 0, 0, 0));
		pending.push_back(mk(K_ADD, 0, 0, 0));
		pending.push_back(mk(K_ADD, 0, 5, 0));
		pending.push_back(mk(K_BEGIN, 0, 0, 0));
		pending.push_back(mk(K_ADD, 0, 0, 0));
		pending.push_back(mk(K_ADD, 65536, 65535, 0));
		pending.push_back(mk(K_FINISH, 0, 0, 0));
		pending.push_back(mk(K_ADD, 1, 1, 0));
		pending.push_back(mk(K_QUERY, 0, 0, 0));
		pending.push_back(mk(K_QUERY, 0, 0, 65536));
		pending.push_back(mk(K_QUERY, 0, 0, 65537));
		pending.push_back(mk(K_QUERY, 0, 0, -131072));
		pending.push_back(mk(K_QUERY, 0, 0, 131071));
		pending.push_back(mk(K_QUERY, 0, 0, 32768));
		load_table(NPTS, 1);
		pending.push_back(mk(K_ADD, 1, 1, 0));
		load_table(NPTS, 1);
		queries(10);
		drain();
		// hold the receiver while items keep coming
		hold_rx = 1;
		queries(20);
		repeat (400) @(posedge clk);
		hold_rx = 0;
		drain();
		quiet = 1;
		queries(60);
		drain();
		quiet = 0;
		for (int b = 0; b < 50; b++) begin
			if ($urandom_range(0, 4) == 0) begin
				pending.push_back(mk(kind_t'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom));
			end
			load_table($urandom_range(0, 5) == 0 ? $urandom_range(2, NPTS) :
				$urandom_range(2, 6), $urandom_range(0, 3) != 0);
			queries($urandom_range(10, 30));
			drain();
		end
		repeat (200) @(posedge clk);
		if (errors == 0) $display("[thrust_to_signal_interpolator] OK");
		else $display("[thrust_to_signal_interpolator] ERROR");
		$finish;
	end

endmodule
